// File: sv/ready_bitmap_priority_scheduler_macros.svh
// assertion macros for the ready bitmap priority scheduler
// no dependencies; defining ASSERT_OFF turns every check into nothing
`ifndef READY_BITMAP_PRIORITY_SCHEDULER_MACROS_SVH
`define READY_BITMAP_PRIORITY_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
`define RBPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rbps assertion failed");
`define RBPS_NEVER(lbl, clk, rst_n, cond) \
  `RBPS_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define RBPS_ASSERT(lbl, clk, rst_n, prop)
`define RBPS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: sv/rbps_pkg.sv
// shared constants, types and helpers of the ready bitmap priority scheduler
// no dependencies
package rbps_pkg;

  localparam int unsigned MaxPriorities = 64;
  localparam int unsigned NumRows       = 8;
  localparam int unsigned RowW          = 8;   // priorities per row
  localparam int unsigned RowAddrW      = 3;   // row part of a priority
  localparam int unsigned ColW          = 3;   // column part of a priority
  localparam int unsigned PrioW         = RowAddrW + ColW;
  localparam int unsigned CountW        = 7;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_SET   = 3'd1,
    OP_UNSET = 3'd2,
    OP_FIND  = 3'd3,
    OP_TRAV  = 3'd4
  } op_e;

  typedef struct packed {
    logic                en;
    logic [RowAddrW-1:0] addr;
    logic [RowW-1:0]     data;
  } ram_wr_t;

  // index of the least significant set bit, 0 for an empty mask
  function automatic logic [ColW-1:0] lowest_bit(input logic [RowW-1:0] v);
    logic [ColW-1:0] idx;
    idx = '0;
    for (int i = RowW - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = ColW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: sv/rbps_row_ram.sv
// row mask storage: one write port, one read port with registered data
// depends on rbps_pkg
module rbps_row_ram (
  input  logic                      clk_i,
  input  rbps_pkg::ram_wr_t         wr_i,
  input  logic                      rd_en_i,
  input  logic [rbps_pkg::RowAddrW-1:0] rd_addr_i,
  output logic [rbps_pkg::RowW-1:0] rd_data_o
);
  import rbps_pkg::*;

  logic [RowW-1:0] mem_q [NumRows];
  logic [RowW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/ready_bitmap_priority_scheduler.sv
// top level of the two-level ready bitmap priority scheduler
// depends on rbps_pkg, rbps_row_ram and ready_bitmap_priority_scheduler_macros.svh
//
// usage
//   a request is taken at a rising edge with start_i high and busy_o low; it
//   carries opcode_i (clear all, set ready, set unready, find highest,
//   traverse) and priority_req_i. every request yields one or more results,
//   each shown for exactly one cycle with result_valid_o high; last_o marks
//   the final result of a request. the receiver cannot stall, so no result
//   ever waits.
//   steps of each request, from acceptance to its last result:
//     clear all, unknown opcode, out-of-range priority, find or traverse on
//     an empty set: result registered at acceptance, busy_o never rises
//     set ready, set unready, find highest: row read, then result
//     traverse: one result per ready priority; the first row is read in the
//     accept cycle, each later row while the row before emits its last one
//   the row memory's single read port with registered data sets these steps;
//   every row update is a read, modify and write back.
//   reset clears the group mask and the control state; the row memory is not
//   cleared, a row whose group bit is clear reads as empty.
module ready_bitmap_priority_scheduler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [2:0]                  opcode_i,
  input  logic [rbps_pkg::PrioW-1:0]  priority_req_i,
  output logic                        result_valid_o,
  output logic                        found_o,
  output logic [rbps_pkg::PrioW-1:0]  ready_priority_o,
  output logic                        any_ready_o,
  output logic [rbps_pkg::CountW-1:0] ready_count_o,
  output logic                        last_o,
  output logic                        range_error_o
);
  import rbps_pkg::*;

`include "ready_bitmap_priority_scheduler_macros.svh"

  // one-hot sequencer states
  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_RMW       = 5'b00010,
    S_FIND      = 5'b00100,
    S_TRAV_RD   = 5'b01000,
    S_TRAV_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // group mask lives in flops, it doubles as the valid bit of each row
  logic [RowW-1:0]     group_q, group_d;
  // rows of the current traverse not yet visited
  logic [RowW-1:0]     rows_q, rows_d;
  // row whose data the memory returns this cycle
  logic [RowAddrW-1:0] row_q, row_d;
  // bits of the current row still to be reported
  logic [RowW-1:0]     bits_q, bits_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic                set_q, set_d;
  logic [ColW-1:0]     col_q, col_d;

  // registered result
  logic                res_valid_q, res_valid_d;
  logic                res_found_q, res_found_d;
  logic [PrioW-1:0]    res_prio_q, res_prio_d;
  logic                res_any_q, res_any_d;
  logic [CountW-1:0]   res_cnt_q, res_cnt_d;
  logic                res_last_q, res_last_d;
  logic                res_err_q, res_err_d;

  // row memory ports
  ram_wr_t             ram_wr;
  logic                rd_en;
  logic [RowAddrW-1:0] rd_addr;
  logic [RowW-1:0]     rd_data;
  logic [RowW-1:0]     row_data;

  // helpers
  logic [RowAddrW-1:0] req_row;
  logic                req_ok;
  logic [RowW-1:0]     col_sel;
  logic [RowW-1:0]     new_row;
  logic [RowW-1:0]     cur_bits;
  logic [ColW-1:0]     cur_col;
  logic [RowW-1:0]     rem_bits;
  logic [RowAddrW-1:0] first_row;
  logic [RowAddrW-1:0] next_row;

  rbps_row_ram u_row_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // a row with its group bit clear is empty, whatever the memory holds
  assign row_data = group_q[row_q] ? rd_data : '0;

  assign req_row = priority_req_i[PrioW-1:ColW];
  assign req_ok  = ({1'b0, priority_req_i} < (PrioW + 1)'(MaxPriorities))
                && ({1'b0, req_row} < (RowAddrW + 1)'(NumRows));

  assign col_sel   = RowW'(1) << col_q;
  assign new_row   = set_q ? (row_data | col_sel) : (row_data & ~col_sel);
  assign cur_bits  = (state_q == S_TRAV_RD) ? row_data : bits_q;
  assign cur_col   = lowest_bit(cur_bits);
  assign rem_bits  = cur_bits & ~(RowW'(1) << cur_col);
  assign first_row = lowest_bit(group_q);
  assign next_row  = lowest_bit(rows_q);

  always_comb begin
    state_d     = state_q;
    group_d     = group_q;
    rows_d      = rows_q;
    row_d       = row_q;
    bits_d      = bits_q;
    cnt_d       = cnt_q;
    set_d       = set_q;
    col_d       = col_q;
    rd_en       = 1'b0;
    rd_addr     = row_q;
    ram_wr      = '0;
    res_valid_d = 1'b0;
    res_found_d = 1'b0;
    res_prio_d  = '0;
    res_cnt_d   = '0;
    res_last_d  = 1'b1;
    res_err_d   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          set_d = (opcode_i == OP_SET);
          col_d = priority_req_i[ColW-1:0];
          unique case (opcode_i)
            OP_CLEAR: begin
              group_d     = '0;
              res_valid_d = 1'b1;
            end
            OP_SET, OP_UNSET: begin
              if (req_ok) begin
                rd_en   = 1'b1;
                rd_addr = req_row;
                row_d   = req_row;
                state_d = S_RMW;
              end else begin
                res_valid_d = 1'b1;
                res_err_d   = 1'b1;
              end
            end
            OP_FIND, OP_TRAV: begin
              if (group_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = first_row;
                row_d   = first_row;
                rows_d  = group_q & ~(RowW'(1) << first_row);
                cnt_d   = '0;
                state_d = (opcode_i == OP_FIND) ? S_FIND : S_TRAV_RD;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_RMW: begin
        // write back the modified row and keep the group bit in step
        ram_wr.en    = 1'b1;
        ram_wr.addr  = row_q;
        ram_wr.data  = new_row;
        group_d[row_q] = |new_row;
        res_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end

      S_FIND: begin
        res_valid_d = 1'b1;
        res_found_d = 1'b1;
        res_prio_d  = {row_q, lowest_bit(row_data)};
        state_d     = S_IDLE;
      end

      S_TRAV_RD, S_TRAV_EMIT: begin
        // report one ready priority a cycle, fetch the next row when done
        cnt_d       = cnt_q + CountW'(1);
        res_valid_d = 1'b1;
        res_found_d = 1'b1;
        res_prio_d  = {row_q, cur_col};
        res_cnt_d   = cnt_q + CountW'(1);
        res_last_d  = 1'b0;
        if (rem_bits != '0) begin
          bits_d  = rem_bits;
          state_d = S_TRAV_EMIT;
        end else if (rows_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = next_row;
          row_d   = next_row;
          rows_d  = rows_q & ~(RowW'(1) << next_row);
          state_d = S_TRAV_RD;
        end else begin
          res_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // any_ready reflects the group mask after this step
    res_any_d = |group_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      group_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      group_q     <= group_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q      <= rows_d;
    row_q       <= row_d;
    bits_q      <= bits_d;
    cnt_q       <= cnt_d;
    set_q       <= set_d;
    col_q       <= col_d;
    res_found_q <= res_found_d;
    res_prio_q  <= res_prio_d;
    res_any_q   <= res_any_d;
    res_cnt_q   <= res_cnt_d;
    res_last_q  <= res_last_d;
    res_err_q   <= res_err_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign result_valid_o   = res_valid_q;
  assign found_o          = res_found_q;
  assign ready_priority_o = res_prio_q;
  assign any_ready_o      = res_any_q;
  assign ready_count_o    = res_cnt_q;
  assign last_o           = res_last_q;
  assign range_error_o    = res_err_q;

  // a request ends only with its last result
  `RBPS_ASSERT(a_busy_fall_last, clk_i, rst_ni,
               $fell(busy_o) |-> (result_valid_o && last_o))
  // a reported priority implies a nonempty set
  `RBPS_NEVER(a_found_empty, clk_i, rst_ni,
              result_valid_o && found_o && !any_ready_o)
  // an error result never reports a priority
  `RBPS_NEVER(a_err_found, clk_i, rst_ni,
              result_valid_o && range_error_o && found_o)
  // only traverse results are followed by more results of the same request
  `RBPS_ASSERT(a_nonlast_found, clk_i, rst_ni,
               (result_valid_o && !last_o) |-> (found_o && busy_o))

endmodule
